>>> rtl/core/ptsf_pkg.sv
// ----------------------------------------------------------------------------
// ptsf_pkg
// Shared types and constants of the printable text stream filter.
// ----------------------------------------------------------------------------
package ptsf_pkg;

	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	typedef enum logic [2:0] {
		REG_SHOW_NP  = 3'd0,
		REG_EOL_MARK = 3'd1,
		REG_SHOW_TAB = 3'd2,
		REG_NUM_MODE = 3'd3,
		REG_SQUEEZE  = 3'd4
	} reg_idx_t;

	localparam logic [1:0] NUM_ALL      = 2'd1;
	localparam logic [1:0] NUM_NONBLANK = 2'd2;

	typedef struct packed {
		logic       show_np;
		logic       dollar_eol;
		logic       show_tab;
		logic [1:0] num_mode;
		logic       squeeze;
	} cfg_t;

	// rendered body of one byte: up to four characters, b[0] first
	typedef struct packed {
		logic [1:0]      cnt_m1;
		logic [3:0][7:0] b;
	} body_t;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_M      = 8'h4D;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_QMARK  = 8'h3F;
	localparam logic [7:0] CH_I      = 8'h49;
	localparam logic [7:0] CH_AT     = 8'h40;
	localparam logic [3:0] CH_DIGIT_HI = 4'h3;
	localparam logic [6:0] CH_DEL    = 7'h7F;
	localparam logic [6:0] CH_CTL_END = 7'h20;

endpackage

>>> rtl/core/ptsf_front.sv
// ----------------------------------------------------------------------------
// ptsf_front
// Accepts bytes, tracks line state and counter, renders each byte into a
// queue entry.
// ----------------------------------------------------------------------------
module ptsf_front #(
	parameter int NUMBER_DIGITS = 6
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ptsf_pkg::cfg_t      cfg,
	input  logic                accept,
	input  logic [7:0]          in_byte,
	output logic                enq,
	output logic [4*NUMBER_DIGITS+$bits(ptsf_pkg::body_t):0] enq_data
);
	import ptsf_pkg::*;

	localparam int BW = 4*NUMBER_DIGITS;

	logic [BW-1:0] bcd_q;
	logic [BW-1:0] bcd_inc;
	logic          prev_nl_q;
	logic          prev2_nl_q;
	logic          is_nl;
	logic          drop;
	logic          numbered;
	body_t         body;

	assign is_nl    = (in_byte == CH_NL);
	assign drop     = cfg.squeeze && prev2_nl_q && prev_nl_q && is_nl;
	assign numbered = prev_nl_q && ((cfg.num_mode == NUM_ALL) ||
		((cfg.num_mode == NUM_NONBLANK) && !is_nl));
	assign enq      = accept && !drop;
	assign enq_data = {numbered, bcd_inc, body};

	// saturating decimal increment
	always_comb begin
		logic       carry;
		logic [3:0] d;
		carry   = 1'b1;
		bcd_inc = bcd_q;
		for (int i = 0; i < NUMBER_DIGITS; i++) begin
			d = bcd_q[4*i +: 4];
			if (carry) begin
				if (d == 4'd9) begin
					bcd_inc[4*i +: 4] = 4'd0;
				end else begin
					bcd_inc[4*i +: 4] = d + 4'd1;
					carry = 1'b0;
				end
			end
		end
		if (carry) begin
			bcd_inc = bcd_q;
		end
	end

	always_comb begin
		logic [6:0] v;
		logic       ctl;
		logic [7:0] sec;
		v    = in_byte[6:0];
		ctl  = (v < CH_CTL_END) || (v == CH_DEL);
		sec  = (v == CH_DEL) ? CH_QMARK : ({1'b0, v} + CH_AT);
		body = '0;
		priority if (is_nl) begin
			if (cfg.dollar_eol) begin
				body.b[0]   = CH_DOLLAR;
				body.b[1]   = CH_NL;
				body.cnt_m1 = 2'd1;
			end else begin
				body.b[0] = CH_NL;
			end
		end else if (in_byte == CH_TAB) begin
			if (cfg.show_tab) begin
				body.b[0]   = CH_CARET;
				body.b[1]   = CH_I;
				body.cnt_m1 = 2'd1;
			end else begin
				body.b[0] = CH_TAB;
			end
		end else if (cfg.show_np) begin
			if (in_byte[7]) begin
				body.b[0] = CH_M;
				body.b[1] = CH_DASH;
				if (ctl) begin
					body.b[2]   = CH_CARET;
					body.b[3]   = sec;
					body.cnt_m1 = 2'd3;
				end else begin
					body.b[2]   = {1'b0, v};
					body.cnt_m1 = 2'd2;
				end
			end else if (ctl) begin
				body.b[0]   = CH_CARET;
				body.b[1]   = sec;
				body.cnt_m1 = 2'd1;
			end else begin
				body.b[0] = in_byte;
			end
		end else begin
			body.b[0] = in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcd_q      <= '0;
			prev_nl_q  <= 1'b1;
			prev2_nl_q <= 1'b0;
		end else if (enq) begin
			prev2_nl_q <= prev_nl_q;
			prev_nl_q  <= is_nl;
			if (numbered) begin
				bcd_q <= bcd_inc;
			end
		end
	end

endmodule

>>> rtl/core/ptsf_queue.sv
// ----------------------------------------------------------------------------
// ptsf_queue
// Short register queue between the front and back parts.
// ----------------------------------------------------------------------------
module ptsf_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd,
	output logic             valid,
	output logic [WIDTH-1:0] rd_data
);
	import ptsf_pkg::*;

	logic [WIDTH-1:0]  mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full    = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign valid   = (cnt_q != '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + QCNT_W'(wr) - QCNT_W'(rd);
		end
	end

endmodule

>>> rtl/core/ptsf_back.sv
// ----------------------------------------------------------------------------
// ptsf_back
// Walks a queue entry out one byte per cycle while pop allows: line number and tab when numbered, then body.
// ----------------------------------------------------------------------------
module ptsf_back #(
	parameter int NUMBER_DIGITS = 6
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  logic [4*NUMBER_DIGITS+$bits(ptsf_pkg::body_t):0] q_data,
	output logic       q_pop,
	input  logic       pop,
	output logic       empty,
	output logic [7:0] out_byte,
	output logic       last_of_run
);
	import ptsf_pkg::*;

	localparam int BW = 4*NUMBER_DIGITS;
	localparam int SW = $clog2(NUMBER_DIGITS + 5);

	logic                 numbered;
	logic [BW-1:0]        bcd;
	body_t                body;
	logic [SW-1:0]        step_q;
	logic [SW-1:0]        s_eff;
	logic [SW-1:0]        boff;
	logic [NUMBER_DIGITS-1:0] blank;
	logic [3:0]           dsel;
	logic                 bsel;
	logic [7:0]           nxt_byte;
	logic                 nxt_last;
	logic                 adv;
	logic                 out_valid_q;
	logic [7:0]           out_byte_q;
	logic                 out_last_q;

	assign {numbered, bcd, body} = q_data;

	assign s_eff    = numbered ? step_q : (step_q + SW'(NUMBER_DIGITS + 1));
	assign boff     = s_eff - SW'(NUMBER_DIGITS + 1);
	assign nxt_last = (s_eff == (SW'(NUMBER_DIGITS + 1) + SW'(body.cnt_m1)));
	assign adv      = q_valid && (!out_valid_q || pop);
	assign q_pop    = adv && nxt_last;

	assign empty       = !out_valid_q;
	assign out_byte    = out_byte_q;
	assign last_of_run = out_last_q;

	// leading zeros print as blanks, lowest digit always shows
	always_comb begin
		logic seen;
		seen = 1'b0;
		for (int i = NUMBER_DIGITS - 1; i >= 0; i--) begin
			seen     = seen | (bcd[4*i +: 4] != 4'd0) | (i == 0);
			blank[i] = !seen;
		end
	end

	always_comb begin
		dsel = 4'd0;
		bsel = 1'b0;
		for (int i = 0; i < NUMBER_DIGITS; i++) begin
			if (s_eff == SW'(NUMBER_DIGITS - 1 - i)) begin
				dsel = bcd[4*i +: 4];
				bsel = blank[i];
			end
		end
	end

	always_comb begin
		priority if (s_eff < SW'(NUMBER_DIGITS)) begin
			nxt_byte = bsel ? CH_SPACE : {CH_DIGIT_HI, dsel};
		end else if (s_eff == SW'(NUMBER_DIGITS)) begin
			nxt_byte = CH_TAB;
		end else begin
			nxt_byte = body.b[boff[1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_byte_q <= nxt_byte;
			out_last_q <= nxt_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			step_q      <= '0;
		end else begin
			if (adv) begin
				out_valid_q <= 1'b1;
				step_q      <= nxt_last ? '0 : (step_q + 1'b1);
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/core/printable_text_stream_filter_unit.sv
// ----------------------------------------------------------------------------
// printable_text_stream_filter_unit
// Caret-notation text filter with optional line numbers and line-end marks.
// ----------------------------------------------------------------------------
// Takes one byte per cycle on the push side whenever the four-entry queue
// between front and back has room; a squeezed newline is taken and leaves
// nothing behind. The back end drains the queue at one output byte per cycle
// while pop allows; an input expands to one output byte if plain, up to four
// for caret/M- forms, plus NUMBER_DIGITS+1 when a line number is printed.
// Configuration is to be written over the APB port only while idle; the block does not enforce it.
module printable_text_stream_filter_unit #(
	parameter int NUMBER_DIGITS = 6
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [7:0]                    in_byte,
	output logic                          empty,
	input  logic                          pop,
	output logic [7:0]                    out_byte,
	output logic                          last_of_run,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ptsf_pkg::ADDR_W-1:0]   paddr,
	input  logic [ptsf_pkg::DATA_W-1:0]   pwdata,
	output logic [ptsf_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);
	import ptsf_pkg::*;

	localparam int EW = 4*NUMBER_DIGITS + $bits(body_t) + 1;

	cfg_t          cfg_q;
	logic          cfg_wr;
	reg_idx_t      reg_idx;
	logic          accept;
	logic          enq;
	logic [EW-1:0] enq_data;
	logic          q_full;
	logic          q_valid;
	logic          q_pop;
	logic [EW-1:0] q_data;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign full    = q_full;
	assign accept  = push && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_SHOW_NP:  cfg_q.show_np    <= pwdata[0];
				REG_EOL_MARK: cfg_q.dollar_eol <= pwdata[0];
				REG_SHOW_TAB: cfg_q.show_tab   <= pwdata[0];
				REG_NUM_MODE: cfg_q.num_mode   <= pwdata[1:0];
				REG_SQUEEZE:  cfg_q.squeeze    <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_SHOW_NP:  prdata = DATA_W'(cfg_q.show_np);
			REG_EOL_MARK: prdata = DATA_W'(cfg_q.dollar_eol);
			REG_SHOW_TAB: prdata = DATA_W'(cfg_q.show_tab);
			REG_NUM_MODE: prdata = DATA_W'(cfg_q.num_mode);
			REG_SQUEEZE:  prdata = DATA_W'(cfg_q.squeeze);
			default:      prdata = '0;
		endcase
	end

	ptsf_front #(
		.NUMBER_DIGITS(NUMBER_DIGITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.accept  (accept),
		.in_byte (in_byte),
		.enq     (enq),
		.enq_data(enq_data)
	);

	ptsf_queue #(
		.WIDTH(EW)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (enq),
		.wr_data(enq_data),
		.full   (q_full),
		.rd     (q_pop),
		.valid  (q_valid),
		.rd_data(q_data)
	);

	ptsf_back #(
		.NUMBER_DIGITS(NUMBER_DIGITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_data     (q_data),
		.q_pop      (q_pop),
		.pop        (pop),
		.empty      (empty),
		.out_byte   (out_byte),
		.last_of_run(last_of_run)
	);

endmodule

>>> rtl/core/ptsf_checker.sv
// ----------------------------------------------------------------------------
// ptsf_checker
// Port-level checks of the text filter, bound to the top level.
// ----------------------------------------------------------------------------
module ptsf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       full,
	input logic       empty,
	input logic       pop,
	input logic [7:0] out_byte,
	input logic       last_of_run,
	input logic       pready
);

	// reset leaves the output empty and the input side not full
	a_reset_clear: assert property (@(posedge clk) !arst_n |=> (empty && !full))
		else $error("outputs not cleared in reset");

	// a waiting result request holds until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(last_of_run)))
		else $error("waiting result changed");

	// the rest of a run follows without a gap
	a_run_cont: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && !last_of_run) |=> !empty)
		else $error("gap inside an output run");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready dropped");

endmodule

bind printable_text_stream_filter_unit ptsf_checker u_ptsf_checker (.*);
